FILE: hdl/b64enc_pkg.sv
package b64enc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [6:0] CHAR_UPPER_A = 7'd65;
	localparam logic [6:0] CHAR_LOWER_A = 7'd97;
	localparam logic [6:0] CHAR_DIGIT_0 = 7'd48;
	localparam logic [6:0] CHAR_PLUS    = 7'd43;
	localparam logic [6:0] CHAR_SLASH   = 7'd47;
	localparam logic [6:0] CHAR_PAD     = 7'd61;

	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  pads;
		logic        last;
	} group_t;

	typedef struct packed {
		logic   push;
		group_t entry;
	} push_t;

	function automatic logic [6:0] alphabet(input logic [5:0] slice);
		logic [6:0] s;
		s = {1'b0, slice};
		if (slice < 6'd26) begin
			return CHAR_UPPER_A + s;
		end else if (slice < 6'd52) begin
			return CHAR_LOWER_A + s - 7'd26;
		end else if (slice < 6'd62) begin
			return CHAR_DIGIT_0 + s - 7'd52;
		end else if (slice == 6'd62) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

FILE: hdl/b64enc_front.sv
module b64enc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                end_of_data,
	input  logic                queue_full,
	output b64enc_pkg::push_t   push
);

	logic [15:0] held_q;
	logic [1:0]  count_q;
	logic        accept;
	logic        close_group;

	assign in_stall    = queue_full;
	assign accept      = in_valid && !queue_full;
	assign close_group = end_of_data || (count_q >= 2'd2);

	always_comb begin
		push.push       = accept && close_group;
		push.entry.last = end_of_data;
		case (count_q)
			2'd0: begin
				push.entry.group = {data_byte, 16'd0};
				push.entry.pads  = end_of_data ? b64enc_pkg::PAD_TWO : b64enc_pkg::PAD_NONE;
			end
			2'd1: begin
				push.entry.group = {held_q[7:0], data_byte, 8'd0};
				push.entry.pads  = end_of_data ? b64enc_pkg::PAD_ONE : b64enc_pkg::PAD_NONE;
			end
			default: begin
				push.entry.group = {held_q, data_byte};
				push.entry.pads  = b64enc_pkg::PAD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 16'd0;
			count_q <= 2'd0;
		end else if (accept) begin
			if (close_group) begin
				held_q  <= 16'd0;
				count_q <= 2'd0;
			end else begin
				held_q  <= {held_q[7:0], data_byte};
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

FILE: hdl/b64enc_queue.sv
module b64enc_queue #(
	parameter int unsigned DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  b64enc_pkg::push_t   push,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output b64enc_pkg::group_t  head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64enc_pkg::group_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push.push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hdl/b64enc_back.sv
module b64enc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_empty,
	input  b64enc_pkg::group_t  head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [6:0]          out_char,
	output logic                final_char
);

	b64enc_pkg::group_t entry_q;
	logic       busy_q;
	logic [1:0] index_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       final_char_q;
	logic       advance;
	logic [5:0] slice;
	logic       is_pad;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = !queue_empty && (!busy_q || (advance && index_q == 2'd3));

	always_comb begin
		case (index_q)
			2'd0:    slice = entry_q.group[23:18];
			2'd1:    slice = entry_q.group[17:12];
			2'd2:    slice = entry_q.group[11:6];
			default: slice = entry_q.group[5:0];
		endcase
		is_pad = ((index_q == 2'd3) && (entry_q.pads != b64enc_pkg::PAD_NONE))
			|| ((index_q == 2'd2) && (entry_q.pads == b64enc_pkg::PAD_TWO));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head;
		end
		if (advance && busy_q) begin
			out_char_q   <= is_pad ? b64enc_pkg::CHAR_PAD : b64enc_pkg::alphabet(slice);
			final_char_q <= entry_q.last && (index_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			index_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q  <= 1'b1;
				index_q <= 2'd0;
			end else if (advance && busy_q) begin
				index_q <= index_q + 2'd1;
				if (index_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign final_char = final_char_q;

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> index_q == 2'd0)
		else $error("Character index is not zero while the back end is idle.");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy_q && index_q == 2'd0)
		else $error("A popped group did not start at its first character.");

	a_group_runs: assert property (@(posedge clk) disable iff (!arst_n)
		advance && busy_q && index_q != 2'd3 |=> busy_q)
		else $error("A group stopped before its fourth character.");

	a_no_early_pop: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && index_q != 2'd3 |-> !pop)
		else $error("A group was popped while the current one was unfinished.");

endmodule

FILE: hdl/base64_stream_encoder_core.sv
// Base64 stream encoder with the standard alphabet and '=' padding.
// The input channel takes one raw byte per request on data_byte, with
// end_of_data set on the final byte of a message. The output channel gives
// one ASCII character per request on out_char, with final_char set on the
// last character of the encoded message.
// Both channels use valid and stall; a request completes on a rising edge
// with valid high and stall low.
// Bytes are gathered in groups of three, or fewer when end_of_data closes
// a group early; the request that closes a group places it in a short
// queue and the back end then produces four characters, one per cycle
// while out_stall is low. The back end pops the group into its entry
// register and then registers each character in the output register.
// in_stall rises only when the queue is full, which happens when groups
// arrive faster than the back end emits their characters or when the
// receiver holds out_stall high for long enough.
// An asynchronous reset on arst_n empties the held bytes, the queue and the
// output register.
module base64_stream_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       final_char
);

	b64enc_pkg::push_t  push;
	b64enc_pkg::group_t head;
	logic queue_full;
	logic queue_empty;
	logic pop;

	b64enc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.queue_full  (queue_full),
		.push        (push)
	);

	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.empty  (queue_empty),
		.pop    (pop),
		.head   (head)
	);

	b64enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.final_char  (final_char)
	);

endmodule

FILE: dv/base64_stream_encoder_core_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_core_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       end_of_data;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] out_char;
	logic       final_char;

	string      b64_symbols =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	enc_char_t  pending_chars[$];
	logic [15:0] held_bytes;
	logic [1:0]  held_count;

	int         error_count;
	int         cycle_count;
	int         bytes_sent;
	int         messages_sent;
	int         chars_checked;
	int         out_wait;
	bit         tx_burst;
	bit         rx_burst;

	base64_stream_encoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.final_char  (final_char)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Expected characters for one accepted byte, following the group and
	// padding rules of the encoding.
	function automatic void encode_byte(input logic [7:0] b, input logic eod);
		logic [23:0] grp;
		logic [5:0]  slice;
		int          pads;
		enc_char_t   rec;
		if (!eod && held_count < 2'd2) begin
			held_bytes = {held_bytes[7:0], b};
			held_count = held_count + 2'd1;
			return;
		end
		case (held_count)
			2'd0: begin
				grp = {b, 16'h0000};
			end
			2'd1: begin
				grp = {held_bytes[7:0], b, 8'h00};
			end
			default: begin
				grp = {held_bytes, b};
			end
		endcase
		if (!eod) begin
			pads = 0;
		end else if (held_count == 2'd0) begin
			pads = 2;
		end else if (held_count == 2'd1) begin
			pads = 1;
		end else begin
			pads = 0;
		end
		for (int k = 0; k < 4; k++) begin
			slice = 6'((grp >> (18 - 6 * k)) & 24'h3F);
			rec.ch = (k >= 4 - pads) ? b64enc_pkg::CHAR_PAD : 7'(b64_symbols[slice]);
			rec.last = eod && (k == 3);
			pending_chars.push_back(rec);
		end
		held_bytes = 16'h0000;
		held_count = 2'd0;
	endfunction

	// Called just after a falling edge; returns just after a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic eod);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_data <= eod;
		forever begin
			@(posedge clk);
			if (in_stall === 1'b0) begin
				break;
			end
		end
		encode_byte(b, eod);
		bytes_sent++;
		if (eod) begin
			messages_sent++;
		end
		@(negedge clk);
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		foreach (msg[i]) begin
			send_byte(msg[i], i == msg.size() - 1);
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending_chars.size() != 0);
	endtask

	task automatic test_directed_groups();
		tx_burst = 1'b0;
		send_message('{8'h00});
		send_message('{8'hFF});
		send_message('{8'h4D, 8'h61});
		send_message('{8'hFF, 8'hFF, 8'hFF});
		send_message('{8'h00, 8'h00, 8'h00});
		send_message('{8'hFB, 8'hEF, 8'hBE, 8'hAA});
		tx_burst = 1'b1;
		send_message('{8'h4D, 8'h61, 8'h6E, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hFE});
		tx_burst = 1'b0;
	endtask

	task automatic test_pause_mid_message();
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		wait_for_drain();
		send_byte(8'hAB, 1'b0);
		wait_for_drain();
		send_byte(8'hCD, 1'b1);
		wait_for_drain();
	endtask

	task automatic test_random_messages(input int byte_budget);
		int first;
		int len;
		first = bytes_sent;
		while (bytes_sent - first < byte_budget) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				send_byte(8'($urandom_range(0, 255)), i == len - 1);
			end
			if ($urandom_range(0, 9) == 0) begin
				wait_for_drain();
			end
		end
		tx_burst = 1'b0;
	endtask

	always @(posedge clk) begin
		enc_char_t exp_rec;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			chars_checked++;
			if ($urandom_range(0, 49) == 0) begin
				rx_burst = !rx_burst;
			end
			out_wait <= rx_burst ? 0 : $urandom_range(0, 12);
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("character %0d arrived with none expected",
					out_char));
			end else begin
				exp_rec = pending_chars.pop_front();
				if (out_char !== exp_rec.ch) begin
					report_mismatch($sformatf("out_char %0d, expected %0d", out_char,
						exp_rec.ch));
				end
				if (final_char !== exp_rec.last) begin
					report_mismatch($sformatf("final_char %b, expected %b", final_char,
						exp_rec.last));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (out_wait > 0) begin
			out_stall <= 1'b1;
			out_wait  <= out_wait - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = 8'h00;
		end_of_data = 1'b0;
		out_stall   = 1'b0;
		out_wait    = 0;
		held_bytes  = 16'h0000;
		held_count  = 2'd0;
		error_count = 0;
		cycle_count = 0;
		bytes_sent  = 0;
		messages_sent = 0;
		chars_checked = 0;
		tx_burst    = 1'b0;
		rx_burst    = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_groups();
		test_pause_mid_message();
		test_random_messages(140);

		wait_for_drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_chars.size() != 0) begin
			report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
		end
		$display("Encoded %0d messages from %0d bytes; %0d characters were checked.",
			messages_sent, bytes_sent, chars_checked);
		$display("Partial and full groups, padding and stalls on both sides were exercised.");
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
